[rtl/jfcs_pkg.sv]
`timescale 1ns / 1ps

package jfcs_pkg;

   // Parser modes; code 15 is never entered and reads as failed.
   typedef enum logic [3:0] {
      MODE_START      = 4'd0,
      MODE_WS_BEFORE  = 4'd1,
      MODE_EOL_BEFORE = 4'd2,
      MODE_SLASH_BEF  = 4'd3,
      MODE_BLK_BEFORE = 4'd4,
      MODE_STAR_BEF   = 4'd5,
      MODE_INNER      = 4'd6,
      MODE_STRING     = 4'd7,
      MODE_ESCAPE     = 4'd8,
      MODE_EOL_IN     = 4'd9,
      MODE_SLASH_IN   = 4'd10,
      MODE_BLK_IN     = 4'd11,
      MODE_STAR_IN    = 4'd12,
      MODE_DONE       = 4'd13,
      MODE_FAILED     = 4'd14
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_PARSING  = 2'd0,
      STATUS_COMPLETE = 2'd1,
      STATUS_FAILED   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_BAD_LEAD   = 2'd1,
      ERR_BAD_SLASH  = 2'd2,
      ERR_DEPTH_OVFL = 2'd3
   } error_type;

   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       chunk_last;
   } req_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic [1:0] feed_status;
      logic [1:0] error_code;
      logic       need_more;
      logic [7:0] nest_depth;
   } rsp_type;

endpackage

[rtl/jfcs_stream_if.sv]
`timescale 1ns / 1ps

interface jfcs_stream_if #(
   parameter type payload_type = logic [7:0]
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/json_frame_comment_stripper.sv]
`timescale 1ns / 1ps
// JSON document framer with comment stripping.
// req_ch carries one stream byte per beat (in_byte, chunk_last); rsp_ch
// returns exactly one result beat for every request beat, in order.
// A result carries the kept byte (out_valid/out_byte), the feed status,
// the error code, need_more and the low 8 bits of the nesting depth.
// A taken beat's result is registered in the output register, or in the
// skid entry if rsp_ch stalls. Throughput: one byte per cycle unless rsp_ch
// stalls; state updates as a beat is taken, so beats may run back to back.
// A two-entry result buffer (output register plus skid) sits on rsp_ch:
// while the receiver stalls one further beat is still taken, then
// req_ch.ready drops until the receiver takes a result. No beat is lost.
// Reset (synchronous, active high) returns the parser to its start mode
// with zero depth and no error, and empties the result buffer.
// Once the document completes or fails, later bytes still produce result
// beats, but with nothing kept and the held status, error and depth.
// MAX_DEPTH bounds the nesting counter; one more opener fails with overflow.
module json_frame_comment_stripper #(
   parameter int MAX_DEPTH = 255
) (
   input  logic                 clock,
   input  logic                 reset,
   jfcs_stream_if.sink          req_ch,
   jfcs_stream_if.source        rsp_ch
);

   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

   // parser state
   jfcs_pkg::mode_type   mode_ff,  mode_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic [1:0]           fail_ff,  fail_in;

   // result buffer
   logic                 out_v_ff,  out_v_in;
   jfcs_pkg::rsp_type    out_ff,    out_in;
   logic                 skid_v_ff, skid_v_in;
   jfcs_pkg::rsp_type    skid_ff,   skid_in;

   jfcs_pkg::rsp_type    rsp_new;
   logic                 keep;
   logic [1:0]           status;
   logic [DEPTH_W+7:0]   depth_ext;
   logic [7:0]           c;
   logic                 acc;
   logic                 out_fire;
   logic                 out_load;

   assign c        = req_ch.payload.in_byte;
   assign acc      = req_ch.valid && req_ch.ready;
   assign out_fire = out_v_ff && rsp_ch.ready;
   assign out_load = !out_v_ff || out_fire;

   assign req_ch.ready   = !skid_v_ff;
   assign rsp_ch.valid   = out_v_ff;
   assign rsp_ch.payload = out_ff;

   // Next parser state for the byte on req_ch.
   always_comb begin
      mode_in  = mode_ff;
      depth_in = depth_ff;
      fail_in  = fail_ff;
      keep     = 1'b0;
      case (mode_ff)
         jfcs_pkg::MODE_START, jfcs_pkg::MODE_WS_BEFORE: begin
            if (c == jfcs_pkg::CH_TAB || c == jfcs_pkg::CH_LF ||
                c == jfcs_pkg::CH_CR || c == jfcs_pkg::CH_SPACE) begin
               mode_in = jfcs_pkg::MODE_WS_BEFORE;
            end else if (c == jfcs_pkg::CH_HASH) begin
               mode_in = jfcs_pkg::MODE_EOL_BEFORE;
            end else if (c == jfcs_pkg::CH_SLASH) begin
               mode_in = jfcs_pkg::MODE_SLASH_BEF;
            end else if (c == jfcs_pkg::CH_LBRACE || c == jfcs_pkg::CH_LBRACKET) begin
               if (depth_ff >= DEPTH_MAX) begin
                  depth_in = DEPTH_MAX;
                  fail_in  = jfcs_pkg::ERR_DEPTH_OVFL;
                  mode_in  = jfcs_pkg::MODE_FAILED;
               end else begin
                  depth_in = depth_ff + 1'b1;
                  mode_in  = jfcs_pkg::MODE_INNER;
                  keep     = 1'b1;
               end
            end else begin
               fail_in = jfcs_pkg::ERR_BAD_LEAD;
               mode_in = jfcs_pkg::MODE_FAILED;
            end
         end
         jfcs_pkg::MODE_EOL_BEFORE: begin
            if (c == jfcs_pkg::CH_LF) mode_in = jfcs_pkg::MODE_WS_BEFORE;
         end
         jfcs_pkg::MODE_SLASH_BEF: begin
            if (c == jfcs_pkg::CH_SLASH) begin
               mode_in = jfcs_pkg::MODE_EOL_BEFORE;
            end else if (c == jfcs_pkg::CH_STAR) begin
               mode_in = jfcs_pkg::MODE_BLK_BEFORE;
            end else begin
               fail_in = jfcs_pkg::ERR_BAD_SLASH;
               mode_in = jfcs_pkg::MODE_FAILED;
            end
         end
         jfcs_pkg::MODE_BLK_BEFORE: begin
            if (c == jfcs_pkg::CH_STAR) mode_in = jfcs_pkg::MODE_STAR_BEF;
         end
         jfcs_pkg::MODE_STAR_BEF: begin
            if (c == jfcs_pkg::CH_SLASH) begin
               mode_in = jfcs_pkg::MODE_WS_BEFORE;
            end else if (c != jfcs_pkg::CH_STAR) begin
               mode_in = jfcs_pkg::MODE_BLK_BEFORE;
            end
         end
         jfcs_pkg::MODE_INNER: begin
            if (c == jfcs_pkg::CH_LBRACE || c == jfcs_pkg::CH_LBRACKET) begin
               if (depth_ff >= DEPTH_MAX) begin
                  depth_in = DEPTH_MAX;
                  fail_in  = jfcs_pkg::ERR_DEPTH_OVFL;
                  mode_in  = jfcs_pkg::MODE_FAILED;
               end else begin
                  depth_in = depth_ff + 1'b1;
                  keep     = 1'b1;
               end
            end else if (c == jfcs_pkg::CH_RBRACE || c == jfcs_pkg::CH_RBRACKET) begin
               // no kind check on closers, only the count
               keep = 1'b1;
               if (depth_ff != '0) depth_in = depth_ff - 1'b1;
               if (depth_ff <= DEPTH_W'(1)) mode_in = jfcs_pkg::MODE_DONE;
            end else if (c == jfcs_pkg::CH_QUOTE) begin
               keep    = 1'b1;
               mode_in = jfcs_pkg::MODE_STRING;
            end else if (c == jfcs_pkg::CH_HASH) begin
               mode_in = jfcs_pkg::MODE_EOL_IN;
            end else if (c == jfcs_pkg::CH_SLASH) begin
               mode_in = jfcs_pkg::MODE_SLASH_IN;
            end else begin
               keep = 1'b1;
            end
         end
         jfcs_pkg::MODE_STRING: begin
            keep = 1'b1;
            if (c == jfcs_pkg::CH_QUOTE) begin
               mode_in = jfcs_pkg::MODE_INNER;
            end else if (c == jfcs_pkg::CH_BACKSLASH) begin
               mode_in = jfcs_pkg::MODE_ESCAPE;
            end
         end
         jfcs_pkg::MODE_ESCAPE: begin
            keep    = 1'b1;
            mode_in = jfcs_pkg::MODE_STRING;
         end
         jfcs_pkg::MODE_EOL_IN: begin
            if (c == jfcs_pkg::CH_LF) begin
               keep    = 1'b1;
               mode_in = jfcs_pkg::MODE_INNER;
            end
         end
         jfcs_pkg::MODE_SLASH_IN: begin
            if (c == jfcs_pkg::CH_SLASH) begin
               mode_in = jfcs_pkg::MODE_EOL_IN;
            end else if (c == jfcs_pkg::CH_STAR) begin
               mode_in = jfcs_pkg::MODE_BLK_IN;
            end else begin
               fail_in = jfcs_pkg::ERR_BAD_SLASH;
               mode_in = jfcs_pkg::MODE_FAILED;
            end
         end
         jfcs_pkg::MODE_BLK_IN: begin
            // line feeds inside a block comment are kept
            if (c == jfcs_pkg::CH_STAR) begin
               mode_in = jfcs_pkg::MODE_STAR_IN;
            end else if (c == jfcs_pkg::CH_LF) begin
               keep = 1'b1;
            end
         end
         jfcs_pkg::MODE_STAR_IN: begin
            if (c == jfcs_pkg::CH_SLASH) begin
               mode_in = jfcs_pkg::MODE_INNER;
            end else if (c != jfcs_pkg::CH_STAR) begin
               keep    = (c == jfcs_pkg::CH_LF);
               mode_in = jfcs_pkg::MODE_BLK_IN;
            end
         end
         default: begin
            // done, failed or the unused code: byte ignored
         end
      endcase
   end

   // Result beat built from the next state.
   always_comb begin
      case (mode_in)
         jfcs_pkg::MODE_DONE: status = jfcs_pkg::STATUS_COMPLETE;
         jfcs_pkg::MODE_FAILED: status = jfcs_pkg::STATUS_FAILED;
         jfcs_pkg::MODE_START, jfcs_pkg::MODE_WS_BEFORE, jfcs_pkg::MODE_EOL_BEFORE,
         jfcs_pkg::MODE_SLASH_BEF, jfcs_pkg::MODE_BLK_BEFORE, jfcs_pkg::MODE_STAR_BEF,
         jfcs_pkg::MODE_INNER, jfcs_pkg::MODE_STRING, jfcs_pkg::MODE_ESCAPE,
         jfcs_pkg::MODE_EOL_IN, jfcs_pkg::MODE_SLASH_IN, jfcs_pkg::MODE_BLK_IN,
         jfcs_pkg::MODE_STAR_IN: status = jfcs_pkg::STATUS_PARSING;
         default: status = jfcs_pkg::STATUS_FAILED;
      endcase
      depth_ext           = {8'd0, depth_in};
      rsp_new.out_valid   = keep;
      rsp_new.out_byte    = keep ? c : 8'd0;
      rsp_new.feed_status = status;
      rsp_new.error_code  = (status == jfcs_pkg::STATUS_FAILED) ? fail_in
                                                                 : jfcs_pkg::ERR_NONE;
      rsp_new.need_more   = req_ch.payload.chunk_last &&
                            (status == jfcs_pkg::STATUS_PARSING);
      rsp_new.nest_depth  = depth_ext[7:0];
   end

   // Result buffer: output register with a skid entry behind it.
   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (out_load) begin
         out_v_in = skid_v_ff || acc;
         out_in   = skid_v_ff ? skid_ff : rsp_new;
         if (skid_v_ff) begin
            skid_v_in = acc;
            skid_in   = rsp_new;
         end
      end else if (acc) begin
         skid_v_in = 1'b1;
         skid_in   = rsp_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= jfcs_pkg::MODE_START;
         depth_ff  <= '0;
         fail_ff   <= jfcs_pkg::ERR_NONE;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (acc) begin
            mode_ff  <= mode_in;
            depth_ff <= depth_in;
            fail_ff  <= fail_in;
         end
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // skid entry only fills behind a held output beat
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry valid with empty output register");

   // depth counter bounded by MAX_DEPTH
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_MAX)
      else $error("nesting depth above limit");

   // a finished document is terminal until reset
   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      mode_ff == jfcs_pkg::MODE_DONE |=> mode_ff == jfcs_pkg::MODE_DONE)
      else $error("left completed mode without reset");

   // error code only alongside a failed status
   a_err_only_failed: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.feed_status != jfcs_pkg::STATUS_FAILED
      |-> out_ff.error_code == jfcs_pkg::ERR_NONE)
      else $error("error code on a non-failed beat");

   // a beat taken once the parser has stopped still yields a result beat
   a_no_keep_after_stop: assert property (@(posedge clock) disable iff (reset)
      acc && (mode_ff == jfcs_pkg::MODE_DONE || mode_ff == jfcs_pkg::MODE_FAILED)
      |=> out_v_ff)
      else $error("beat lost after parser stopped");

endmodule
